FILE: hw/rtl/avut_pkg.sv
// Package for the angle unwrap and velocity tracker.
// Widths, register codes, reset values, constants and shared types.
// No dependencies.
`timescale 1ns / 1ps

package avut_pkg;

	localparam int ANGLE_BITS = 12;
	localparam int TURN_BITS  = 16;
	localparam int TIME_BITS  = 32;

	// position = {-turns (one bit wider), angle}
	localparam int POS_W = TURN_BITS + 1 + ANGLE_BITS;
	// |dturns * 2^ANGLE_BITS - dangle| stays below 2^(TURN_BITS + ANGLE_BITS)
	localparam int MAG_W = TURN_BITS + ANGLE_BITS;
	localparam int NUM_W = MAG_W + 1;

	localparam int VEL_W  = 32;
	localparam int QUOT_W = VEL_W - 1;

	// 10^6 = 15625 * 2^6: multiply by the odd part, then shift
	localparam int                  US_ODD_W     = 14;
	localparam logic [US_ODD_W-1:0] US_ODD       = 14'd15625;
	localparam int                  US_ODD_IDX_W = $clog2(US_ODD_W);
	localparam int                  US_SHIFT     = 6;
	localparam int                  PROD_W       = MAG_W + US_ODD_W;
	localparam int                  DVD_W        = PROD_W + US_SHIFT;
	localparam int                  STEP_W       = $clog2(DVD_W);

	localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int FB_W       = 16;

	localparam logic [ANGLE_BITS-1:0] WRAP_RESET     = 12'd3277;
	localparam logic [FB_W-1:0]       FALLBACK_RESET = 16'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WRAP_THRESHOLD    = 1'b0,
		REG_FALLBACK_INTERVAL = 1'b1
	} avut_reg_t;

	typedef enum logic {
		CMD_SAMPLE   = 1'b0,
		CMD_VELOCITY = 1'b1
	} avut_cmd_t;

	typedef enum logic [1:0] {
		VEL_IDLE,
		VEL_MUL,
		VEL_DIV,
		VEL_DONE
	} avut_vel_state_t;

	typedef struct packed {
		logic                 start;
		logic                 neg;
		logic [MAG_W-1:0]     mag;
		logic [TIME_BITS-1:0] dt;
	} avut_vel_req_t;

	typedef struct packed {
		logic             done;
		logic             clipped;
		logic [VEL_W-1:0] vel;
	} avut_vel_rsp_t;

endpackage

FILE: hw/rtl/avut_in_if.sv
// Input channel of the tracker: command, angle and timestamp word.
// Depends on avut_pkg.
`timescale 1ns / 1ps

interface avut_in_if;
	logic                                valid;
	logic                                ready;
	logic                                command;
	logic [avut_pkg::ANGLE_BITS-1:0]     angle_count;
	logic [avut_pkg::TIME_BITS-1:0]      timestamp_us;

	modport source (output valid, command, angle_count, timestamp_us, input ready);
	modport sink   (input valid, command, angle_count, timestamp_us, output ready);
endinterface

FILE: hw/rtl/avut_out_if.sv
// Result channel of the tracker: position, turns and velocity word.
// Depends on avut_pkg.
`timescale 1ns / 1ps

interface avut_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [avut_pkg::POS_W-1:0]  position_count;
	logic signed [avut_pkg::TURN_BITS-1:0] turns;
	logic signed [avut_pkg::VEL_W-1:0]  velocity_cps;
	logic                               velocity_valid;
	logic                               velocity_clipped;

	modport source (output valid, position_count, turns, velocity_cps, velocity_valid,
		velocity_clipped, input ready);
	modport sink   (input valid, position_count, turns, velocity_cps, velocity_valid,
		velocity_clipped, output ready);
endinterface

FILE: hw/rtl/avut_cfg_if.sv
// Configuration write channel of the tracker: register index and data word.
// Depends on avut_pkg.
`timescale 1ns / 1ps

interface avut_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [avut_pkg::CFG_IDX_W-1:0]      index;
	logic [avut_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/avut_tracker.sv
// Angle unwrap state: last sample, turn counter and velocity reference.
// Forms the position word and the velocity numerator and interval. Depends on avut_pkg.
`timescale 1ns / 1ps

module avut_tracker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_we,
	input  logic                                 ref_we,
	input  logic [avut_pkg::ANGLE_BITS-1:0]      angle,
	input  logic [avut_pkg::TIME_BITS-1:0]       timestamp,
	input  logic [avut_pkg::ANGLE_BITS-1:0]      wrap_threshold,
	input  logic [avut_pkg::FB_W-1:0]            fallback_interval,
	output avut_pkg::avut_vel_req_t              vel_req,
	output logic [avut_pkg::POS_W-1:0]           position,
	output logic [avut_pkg::TURN_BITS-1:0]       turns
);

	localparam int A = avut_pkg::ANGLE_BITS;
	localparam int T = avut_pkg::TURN_BITS;

	logic [A-1:0]                   last_angle_q;
	logic [T-1:0]                   turn_q;
	logic [avut_pkg::TIME_BITS-1:0] last_time_q;
	logic [A-1:0]                   ref_angle_q;
	logic [T-1:0]                   ref_turns_q;
	logic [avut_pkg::TIME_BITS-1:0] ref_time_q;

	logic [A:0]                     jump;
	logic [A:0]                     jump_abs;
	logic                           wrap;
	logic [T-1:0]                   turn_next;
	logic [A-1:0]                   sel_angle;
	logic [T-1:0]                   sel_turns;
	logic [T:0]                     neg_turns;

	logic [T:0]                     dturns;
	logic [A:0]                     dangle;
	logic [avut_pkg::NUM_W-1:0]     num;
	logic [avut_pkg::NUM_W-1:0]     num_abs;
	logic [avut_pkg::TIME_BITS-1:0] dt_raw;
	logic [avut_pkg::TIME_BITS-1:0] dt_eff;

	always_comb begin
		jump      = {1'b0, angle} - {1'b0, last_angle_q};
		jump_abs  = jump[A] ? (~jump + 1'b1) : jump;
		wrap      = jump_abs >= {1'b0, wrap_threshold};
		turn_next = turn_q;
		if (wrap) begin
			turn_next = jump[A] ? (turn_q - 1'b1) : (turn_q + 1'b1);
		end

		// a sample shows its own updated state in the result word
		sel_angle = sample_we ? angle : last_angle_q;
		sel_turns = sample_we ? turn_next : turn_q;
		neg_turns = ~{sel_turns[T-1], sel_turns} + 1'b1;
		position  = {neg_turns, sel_angle};
		turns     = sel_turns;
	end

	always_comb begin
		dturns  = {turn_q[T-1], turn_q} - {ref_turns_q[T-1], ref_turns_q};
		dangle  = {1'b0, last_angle_q} - {1'b0, ref_angle_q};
		num     = {dturns, {A{1'b0}}} - {{(avut_pkg::NUM_W-A-1){dangle[A]}}, dangle};
		num_abs = num[avut_pkg::NUM_W-1] ? (~num + 1'b1) : num;
		dt_raw  = last_time_q - ref_time_q;
		if (dt_raw != '0) begin
			dt_eff = dt_raw;
		end else if (fallback_interval != '0) begin
			dt_eff = avut_pkg::TIME_BITS'(fallback_interval);
		end else begin
			dt_eff = avut_pkg::TIME_BITS'(1);
		end
		vel_req.start = ref_we;
		vel_req.neg   = num[avut_pkg::NUM_W-1];
		vel_req.mag   = num_abs[avut_pkg::MAG_W-1:0];
		vel_req.dt    = dt_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_angle_q <= '0;
			turn_q       <= '0;
			last_time_q  <= '0;
			ref_angle_q  <= '0;
			ref_turns_q  <= '0;
			ref_time_q   <= '0;
		end else begin
			if (sample_we) begin
				last_angle_q <= angle;
				turn_q       <= turn_next;
				last_time_q  <= timestamp;
			end
			// the numerator has been captured by the velocity unit on this edge
			if (ref_we) begin
				ref_angle_q <= last_angle_q;
				ref_turns_q <= turn_q;
				ref_time_q  <= last_time_q;
			end
		end
	end

endmodule

FILE: hw/rtl/avut_velocity.sv
// Serial velocity unit: bit-serial multiply by 10^6, then restoring division
// by the interval, one quotient bit a cycle, with saturation. Depends on avut_pkg.
`timescale 1ns / 1ps

module avut_velocity (
	input  logic                    clk,
	input  logic                    arst_n,
	input  avut_pkg::avut_vel_req_t req,
	input  logic                    take,
	output avut_pkg::avut_vel_rsp_t rsp
);

	avut_pkg::avut_vel_state_t state_q, state_d;

	logic [avut_pkg::STEP_W-1:0]    step_q;
	logic [avut_pkg::MAG_W-1:0]     mag_q;
	logic                           neg_q;
	logic [avut_pkg::TIME_BITS-1:0] dt_q;
	logic [avut_pkg::PROD_W-1:0]    acc_q;
	logic [avut_pkg::DVD_W-1:0]     dvd_q;
	logic [avut_pkg::TIME_BITS-1:0] rem_q;
	logic [avut_pkg::QUOT_W-1:0]    quot_q;
	logic                           ovf_q;

	logic [avut_pkg::PROD_W-1:0]    acc_next;
	logic [avut_pkg::TIME_BITS:0]   shifted;
	logic                           fits;
	logic [avut_pkg::TIME_BITS-1:0] rem_next;
	logic [avut_pkg::QUOT_W-1:0]    vel_abs;
	logic [avut_pkg::VEL_W-1:0]     vel_ext;

	always_comb begin
		state_d = state_q;
		case (state_q)
			avut_pkg::VEL_IDLE: if (req.start) state_d = avut_pkg::VEL_MUL;
			avut_pkg::VEL_MUL:  if (step_q == '0) state_d = avut_pkg::VEL_DIV;
			avut_pkg::VEL_DIV:  if (step_q == '0) state_d = avut_pkg::VEL_DONE;
			avut_pkg::VEL_DONE: if (take) state_d = avut_pkg::VEL_IDLE;
			default:            state_d = avut_pkg::VEL_IDLE;
		endcase
	end

	always_comb begin
		acc_next = {acc_q[avut_pkg::PROD_W-2:0], 1'b0};
		if (avut_pkg::US_ODD[step_q[avut_pkg::US_ODD_IDX_W-1:0]]) begin
			acc_next = acc_next + avut_pkg::PROD_W'(mag_q);
		end
		shifted  = {rem_q, dvd_q[avut_pkg::DVD_W-1]};
		fits     = shifted >= {1'b0, dt_q};
		rem_next = fits ? avut_pkg::TIME_BITS'(shifted - {1'b0, dt_q})
			: shifted[avut_pkg::TIME_BITS-1:0];

		vel_abs = ovf_q ? avut_pkg::VEL_MAX[avut_pkg::QUOT_W-1:0] : quot_q;
		vel_ext = {1'b0, vel_abs};
		rsp.done    = state_q == avut_pkg::VEL_DONE;
		rsp.clipped = ovf_q;
		rsp.vel     = neg_q ? (~vel_ext + 1'b1) : vel_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= avut_pkg::VEL_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				avut_pkg::VEL_IDLE: step_q <= avut_pkg::STEP_W'(avut_pkg::US_ODD_W - 1);
				avut_pkg::VEL_MUL: begin
					step_q <= (step_q == '0) ? avut_pkg::STEP_W'(avut_pkg::DVD_W - 1)
						: step_q - 1'b1;
				end
				avut_pkg::VEL_DIV:  step_q <= step_q - 1'b1;
				default:            step_q <= step_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			avut_pkg::VEL_IDLE: begin
				if (req.start) begin
					mag_q <= req.mag;
					neg_q <= req.neg;
					dt_q  <= req.dt;
					acc_q <= '0;
				end
			end
			avut_pkg::VEL_MUL: begin
				acc_q <= acc_next;
				if (step_q == '0) begin
					dvd_q  <= {acc_next, {avut_pkg::US_SHIFT{1'b0}}};
					rem_q  <= '0;
					quot_q <= '0;
					ovf_q  <= 1'b0;
				end
			end
			avut_pkg::VEL_DIV: begin
				dvd_q  <= {dvd_q[avut_pkg::DVD_W-2:0], 1'b0};
				rem_q  <= rem_next;
				quot_q <= {quot_q[avut_pkg::QUOT_W-2:0], fits};
				// a quotient bit pushed out at the top means the result will not fit
				ovf_q  <= ovf_q | quot_q[avut_pkg::QUOT_W-1];
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/angle_unwrap_velocity_tracker_unit.sv
// Angle unwrap and velocity tracker, top level.
// Sample word: result registered in the cycle after acceptance; one sample a cycle while
// the output is free or taken and no velocity word is in progress. Velocity word: 14 multiply
// and 48 divide steps in the serial velocity unit; input held off until it is delivered.
// Reset (arst_n, asynchronous): state and references zero, registers to defaults.
// Depends on avut_pkg, avut_in_if, avut_out_if, avut_cfg_if, avut_tracker, avut_velocity.
`timescale 1ns / 1ps

module angle_unwrap_velocity_tracker_unit (
	input  logic             clk,
	input  logic             arst_n,
	avut_in_if.sink          req,
	avut_out_if.source       rsp,
	avut_cfg_if.sink         cfg
);

	logic [avut_pkg::ANGLE_BITS-1:0] wrap_q;
	logic [avut_pkg::FB_W-1:0]       fb_q;
	logic                            busy_q;
	logic                            out_valid_q;

	logic                            slot_free;
	logic                            in_acc;
	logic                            sample_acc;
	logic                            vel_acc;
	logic                            vel_take;

	avut_pkg::avut_vel_req_t         vel_req;
	avut_pkg::avut_vel_rsp_t         vel_rsp;
	logic [avut_pkg::POS_W-1:0]      position;
	logic [avut_pkg::TURN_BITS-1:0]  turns;

	assign slot_free  = !out_valid_q || rsp.ready;
	assign req.ready  = !busy_q && slot_free;
	assign in_acc     = req.valid && req.ready;
	assign sample_acc = in_acc && (req.command == avut_pkg::CMD_SAMPLE);
	assign vel_acc    = in_acc && (req.command == avut_pkg::CMD_VELOCITY);
	assign vel_take   = vel_rsp.done && slot_free;
	assign cfg.ready  = 1'b1;
	assign rsp.valid  = out_valid_q;

	avut_tracker u_tracker (
		.clk               (clk),
		.arst_n            (arst_n),
		.sample_we         (sample_acc),
		.ref_we            (vel_acc),
		.angle             (req.angle_count),
		.timestamp         (req.timestamp_us),
		.wrap_threshold    (wrap_q),
		.fallback_interval (fb_q),
		.vel_req           (vel_req),
		.position          (position),
		.turns             (turns)
	);

	avut_velocity u_velocity (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (vel_req),
		.take   (vel_take),
		.rsp    (vel_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= avut_pkg::WRAP_RESET;
			fb_q   <= avut_pkg::FALLBACK_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				avut_pkg::REG_WRAP_THRESHOLD:    wrap_q <= cfg.data[avut_pkg::ANGLE_BITS-1:0];
				avut_pkg::REG_FALLBACK_INTERVAL: fb_q   <= cfg.data[avut_pkg::FB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (vel_acc) begin
				busy_q <= 1'b1;
			end else if (vel_take) begin
				busy_q <= 1'b0;
			end
			if (sample_acc || vel_take) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word register: load on a sample or a finished velocity
	always_ff @(posedge clk) begin
		if (sample_acc || vel_take) begin
			rsp.position_count   <= position;
			rsp.turns            <= turns;
			rsp.velocity_cps     <= vel_take ? vel_rsp.vel : '0;
			rsp.velocity_valid   <= vel_take;
			rsp.velocity_clipped <= vel_take && vel_rsp.clipped;
		end
	end

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.ready)
		else $error("input accepted while a velocity word is in progress");

	a_vel_starts_unit: assert property (@(posedge clk) disable iff (!arst_n)
		vel_acc |=> (busy_q && !vel_rsp.done))
		else $error("velocity command did not start the velocity unit");

	a_sample_word_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.velocity_valid) |->
		(rsp.velocity_cps == '0 && !rsp.velocity_clipped))
		else $error("sample word carries a velocity");

	a_clip_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp.velocity_clipped) |->
		(rsp.velocity_cps == avut_pkg::VEL_MAX ||
		 rsp.velocity_cps == (~avut_pkg::VEL_MAX + 1'b1)))
		else $error("clipped velocity is not at full scale");

	a_done_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vel_rsp.done |-> busy_q)
		else $error("velocity unit finished without a pending command");

endmodule
